@@ rtl/core/mecsr_pkg.sv @@
// Shared constants, types and lookup functions for the mecanum step-rate drive.
`timescale 1ns / 1ps
`default_nettype none
package mecsr_pkg;

  localparam int WHEELS     = 4;
  localparam int COUNT_BITS = 10;
  localparam int DIV_W      = 23;
  localparam int DEN_W      = 15;
  localparam int DCNT_W     = 5;

  localparam logic [15:0] FULL_Q88  = 16'd25600;
  localparam logic [15:0] LOW_Q88   = 16'd3328;
  localparam logic [23:0] DIV_OFFS  = 24'd32768;

  // Reciprocal of 5 scaled by 2^24 and rounded up; exact for dividends below 2^21.
  localparam logic [21:0] RECIP5    = 22'd3355444;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_TIME_FAC  = 3'd1;
  localparam logic [2:0] REG_TOP_MAN   = 3'd2;
  localparam logic [2:0] REG_TOP_AUTO  = 3'd3;
  localparam logic [2:0] REG_CEILING   = 3'd4;

  // Motion codes.
  localparam logic [3:0] MOT_STOP = 4'd0;
  localparam logic [3:0] MOT_FW   = 4'd1;
  localparam logic [3:0] MOT_BW   = 4'd2;
  localparam logic [3:0] MOT_L    = 4'd3;
  localparam logic [3:0] MOT_R    = 4'd4;
  localparam logic [3:0] MOT_FWL  = 4'd5;
  localparam logic [3:0] MOT_FWR  = 4'd6;
  localparam logic [3:0] MOT_BWL  = 4'd7;
  localparam logic [3:0] MOT_BWR  = 4'd8;
  localparam logic [3:0] MOT_TL   = 4'd9;
  localparam logic [3:0] MOT_TR   = 4'd10;
  localparam logic [3:0] MOT_FWTL = 4'd11;
  localparam logic [3:0] MOT_FWTR = 4'd12;
  localparam logic [3:0] MOT_BWTL = 4'd13;
  localparam logic [3:0] MOT_BWTR = 4'd14;
  localparam logic [7:0] MOT_LAST = 8'd14;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SPD  = 6'b000010,
    ST_SPDW = 6'b000100,
    ST_PER  = 6'b001000,
    ST_PERW = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  typedef logic signed [7:0] target_t;

  // Distance of a stick byte from center, on a 0..25500 scale.
  function automatic logic [15:0] stick_mag(input logic [7:0] b);
    logic [15:0] p;
    p = 16'(b) * 16'd200;
    return (p >= 16'd25500) ? (p - 16'd25500) : (16'd25500 - p);
  endfunction

  // Sort the three sticks into one motion.
  function automatic logic [3:0] classify(input logic [7:0] tb, input logic [7:0] sb,
                                          input logic [7:0] db, input logic lost,
                                          input logic [6:0] thr);
    logic [15:0] lim;
    logic t, s, f, tr, sr, fw;
    logic [3:0] m;
    lim = 16'(thr) * 16'd255;
    t  = (lost ? 16'd0 : stick_mag(tb)) >= lim;
    s  = (lost ? 16'd0 : stick_mag(sb)) >= lim;
    f  = (lost ? 16'd0 : stick_mag(db)) >= lim;
    tr = lost || tb >= 8'd128;
    sr = lost || sb >= 8'd128;
    fw = lost || db <= 8'd127;
    if (!t && !s && f) m = fw ? MOT_FW : MOT_BW;
    else if (!t && s && !f) m = sr ? MOT_R : MOT_L;
    else if (t && !s && !f) m = tr ? MOT_TR : MOT_TL;
    else if (s && f) m = fw ? (sr ? MOT_FWR : MOT_FWL) : (sr ? MOT_BWR : MOT_BWL);
    else if (t && !s && f) m = fw ? (tr ? MOT_FWTR : MOT_FWTL) : (tr ? MOT_BWTR : MOT_BWTL);
    else m = MOT_STOP;
    return m;
  endfunction

  // Wheel targets of a motion, wheel 0 in the low byte.
  function automatic logic [31:0] targets_of(input logic [3:0] m);
    logic [31:0] r;
    case (m)
      MOT_STOP: r = {8'sd0, 8'sd0, 8'sd0, 8'sd0};
      MOT_FW:   r = {-8'sd100, -8'sd100, -8'sd100, -8'sd100};
      MOT_BW:   r = {8'sd100, 8'sd100, 8'sd100, 8'sd100};
      MOT_L:    r = {-8'sd100, 8'sd100, 8'sd100, -8'sd100};
      MOT_R:    r = {8'sd100, -8'sd100, -8'sd100, 8'sd100};
      MOT_FWL:  r = {-8'sd100, 8'sd0, 8'sd0, -8'sd100};
      MOT_FWR:  r = {8'sd0, -8'sd100, -8'sd100, 8'sd0};
      MOT_BWL:  r = {8'sd0, 8'sd100, 8'sd100, 8'sd0};
      MOT_BWR:  r = {8'sd100, 8'sd0, 8'sd0, 8'sd100};
      MOT_TL:   r = {8'sd100, -8'sd100, 8'sd100, -8'sd100};
      MOT_TR:   r = {-8'sd100, 8'sd100, -8'sd100, 8'sd100};
      MOT_FWTL: r = {8'sd0, -8'sd100, 8'sd0, -8'sd100};
      MOT_FWTR: r = {-8'sd100, 8'sd0, -8'sd100, 8'sd0};
      MOT_BWTL: r = {8'sd100, 8'sd0, 8'sd100, 8'sd0};
      MOT_BWTR: r = {8'sd0, 8'sd100, 8'sd0, 8'sd100};
      default:  r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/mecsr_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, shared by all wheels.
`timescale 1ns / 1ps
`default_nettype none
module mecsr_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [mecsr_pkg::DIV_W-1:0]   dividend,
  input  wire logic [mecsr_pkg::DEN_W-1:0]   divisor,
  output logic                               busy,
  output logic                               done,
  output logic [mecsr_pkg::DIV_W-1:0]        quotient
);
  import mecsr_pkg::*;

  logic [DEN_W:0]   rem_r;
  logic [DIV_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [DCNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W+1:0] trial;
  logic [DEN_W+1:0] shifted;

  // Shift in the next dividend bit and try a subtraction.
  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign trial   = shifted - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DIV_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Datapath: remainder never exceeds the divisor, so it fits one extra bit.
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      if (shifted >= {2'b00, den_r}) begin
        rem_r <= trial[DEN_W:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DEN_W:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

@@ rtl/core/mecanum_step_rate_drive_top.sv @@
// Top level of the mecanum step-rate drive: sequencer, wheel state and output beat.
`timescale 1ns / 1ps
`default_nettype none
// A tick beat's result is registered and appears in the cycle after it is taken.
// An update beat walks the four wheels in turn. Each wheel works out its smoothed
// speed in ST_SPD (a constant reciprocal multiply) and ST_SPDW (saturation) and,
// when its speed is between the low and full limits, its step half-period in one
// shared radix-2 divider (ST_PER starts it, ST_PERW waits for the quotient). The
// input is stalled while the wheels are walked and while a result waits.
module mecanum_step_rate_drive_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [9:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_turn_stick,
  input  wire logic [7:0]  in_side_stick,
  input  wire logic [7:0]  in_drive_stick,
  input  wire logic        in_link_lost,
  input  wire logic        in_auto_mode,
  input  wire logic [7:0]  in_host_direction,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_step_levels,
  output logic [3:0]       out_dir_levels,
  output logic [3:0]       out_motion_code,
  output logic signed [15:0] out_front_left_speed,
  output logic signed [15:0] out_front_right_speed,
  output logic signed [15:0] out_rear_left_speed,
  output logic signed [15:0] out_rear_right_speed
);
  import mecsr_pkg::*;

  logic [6:0] thr_r;
  logic [7:0] tf_r, tpm_r, tpa_r;
  logic [9:0] ceil_r;

  logic signed [15:0]  speed_r [WHEELS];
  target_t             target_r [WHEELS];
  logic [9:0]          half_r [WHEELS];
  logic [COUNT_BITS-1:0] cnt_r [WHEELS];
  logic [WHEELS-1:0]   lvl_r;

  state_t     state_r;
  logic [1:0] widx_r;
  logic [3:0] motion_r;
  logic       auto_r;
  logic       zero_r;
  logic [14:0] a_r;
  logic [DIV_W-1:0] spd_q_r;

  logic       out_valid_r;
  logic       out_free;
  logic       accept;

  // Divider connections.
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DEN_W-1:0] div_divisor;
  logic             div_busy;
  logic             div_done;
  logic [DIV_W-1:0] div_q;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= 7'd35;
      tf_r   <= 8'd50;
      tpm_r  <= 8'd10;
      tpa_r  <= 8'd13;
      ceil_r <= 10'd300;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r  <= cfg_wdata[6:0];
        REG_TIME_FAC:  tf_r   <= cfg_wdata[7:0];
        REG_TOP_MAN:   tpm_r  <= cfg_wdata[7:0];
        REG_TOP_AUTO:  tpa_r  <= cfg_wdata[7:0];
        REG_CEILING:   ceil_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Motion choice and new targets of an update beat.
  logic [3:0]  cls;
  logic [7:0]  mot_sel;
  logic        mot_ok;
  logic [31:0] tgt_new;
  logic        zero_new;
  always_comb begin
    cls      = classify(in_turn_stick, in_side_stick, in_drive_stick, in_link_lost, thr_r);
    mot_sel  = in_auto_mode ? in_host_direction : {4'd0, cls};
    mot_ok   = mot_sel <= MOT_LAST;
    tgt_new  = mot_ok ? targets_of(mot_sel[3:0])
                      : {target_r[3], target_r[2], target_r[1], target_r[0]};
    zero_new = (tgt_new == 32'd0);
  end

  // Tick step: counters advance and step levels toggle.
  logic [COUNT_BITS-1:0] cnt_inc [WHEELS];
  logic [WHEELS-1:0]     tog;
  always_comb begin
    for (int i = 0; i < WHEELS; i++) begin
      cnt_inc[i] = cnt_r[i] + 1'b1;
      tog[i] = (half_r[i] != 10'd0) && ({{(16-COUNT_BITS){1'b0}}, cnt_inc[i]} >=
                                       {6'd0, half_r[i]});
    end
  end

  // Smoothing numerator for the current wheel, offset so it stays positive.
  logic signed [24:0] v_ext, t_ext, num2;
  logic [20:0]        spd_n;
  logic [42:0]        spd_prod;
  logic [DIV_W-1:0]   spd_q;
  always_comb begin
    v_ext = 25'(speed_r[widx_r]);
    t_ext = 25'(target_r[widx_r]) * 25'sd256;
    if (zero_r) num2 = v_ext * 25'sd74 + t_ext * 25'sd6 + 25'sd40 + 25'sd2621440;
    else        num2 = v_ext * 25'sd18 + t_ext * 25'sd2 + 25'sd10 + 25'sd655360;
    // Divide by 80 or 20: drop four or two bits, then multiply by the reciprocal of 5.
    spd_n    = zero_r ? {2'b00, num2[22:4]} : num2[22:2];
    spd_prod = 43'(spd_n) * 43'(RECIP5);
    spd_q    = DIV_W'(spd_prod[42:24]);
  end

  // Rounded speed from the registered quotient, saturated, and its magnitude.
  logic signed [23:0] r_raw;
  logic signed [15:0] r_sat;
  logic [14:0]        r_abs;
  logic [7:0]         top;
  always_comb begin
    r_raw = $signed({1'b0, spd_q_r}) - $signed(DIV_OFFS);
    if (r_raw > 24'sd25600)       r_sat = 16'sd25600;
    else if (r_raw < -24'sd25600) r_sat = -16'sd25600;
    else                          r_sat = r_raw[15:0];
    r_abs = r_sat[15] ? 15'(-r_sat) : r_sat[14:0];
    top   = auto_r ? tpa_r : tpm_r;
  end

  // Half-period from the divider quotient.
  logic [DIV_W-1:0] p_raw;
  logic [9:0]       p_clamp;
  always_comb begin
    p_raw   = div_q - DIV_W'(tf_r) + DIV_W'(top);
    p_clamp = (p_raw > DIV_W'(ceil_r)) ? ceil_r : p_raw[9:0];
  end

  // Divider requests.
  always_comb begin
    div_start    = (state_r == ST_PER);
    div_dividend = DIV_W'(23'd25600 * 23'(tf_r));
    div_divisor  = a_r;
  end

  mecsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer and wheel state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      widx_r  <= 2'd0;
      lvl_r   <= '0;
      for (int i = 0; i < WHEELS; i++) begin
        speed_r[i]  <= '0;
        target_r[i] <= '0;
        half_r[i]   <= '0;
        cnt_r[i]    <= '0;
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept && in_action) begin
            for (int i = 0; i < WHEELS; i++) begin
              cnt_r[i] <= tog[i] ? '0 : cnt_inc[i];
            end
            lvl_r <= lvl_r ^ tog;
          end else if (accept) begin
            for (int i = 0; i < WHEELS; i++) begin
              target_r[i] <= tgt_new[8*i +: 8];
            end
            widx_r  <= 2'd0;
            state_r <= ST_SPD;
          end
        end
        ST_SPD: begin
          spd_q_r <= spd_q;
          state_r <= ST_SPDW;
        end
        ST_SPDW: begin
          speed_r[widx_r] <= r_sat;
          a_r <= r_abs;
          if ({1'b0, r_abs} >= FULL_Q88) begin
            half_r[widx_r] <= {2'b00, top};
            state_r <= (widx_r == 2'd3) ? ST_OUT : ST_SPD;
            widx_r  <= widx_r + 1'b1;
          end else if ({1'b0, r_abs} > LOW_Q88) begin
            state_r <= ST_PER;
          end else begin
            half_r[widx_r] <= '0;
            state_r <= (widx_r == 2'd3) ? ST_OUT : ST_SPD;
            widx_r  <= widx_r + 1'b1;
          end
        end
        ST_PER: state_r <= ST_PERW;
        ST_PERW: begin
          if (div_done) begin
            half_r[widx_r] <= p_clamp;
            state_r <= (widx_r == 2'd3) ? ST_OUT : ST_SPD;
            widx_r  <= widx_r + 1'b1;
          end
        end
        ST_OUT: begin
          if (out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Update fields that live through the walk.
  always_ff @(posedge clk) begin
    if (accept && !in_action) begin
      motion_r <= mot_ok ? mot_sel[3:0] : MOT_STOP;
      auto_r   <= in_auto_mode;
      zero_r   <= zero_new;
    end
  end

  // Output beat register.
  logic out_load_tick, out_load_upd;
  assign out_load_tick = accept && in_action;
  assign out_load_upd  = (state_r == ST_OUT) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load_tick || out_load_upd) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_tick || out_load_upd) begin
      out_step_levels <= out_load_tick ? (lvl_r ^ tog) : lvl_r;
      out_motion_code <= out_load_tick ? MOT_STOP : motion_r;
      out_dir_levels  <= {~speed_r[3][15], speed_r[2][15], ~speed_r[1][15], speed_r[0][15]};
      out_front_left_speed  <= speed_r[0];
      out_front_right_speed <= speed_r[1];
      out_rear_left_speed   <= speed_r[2];
      out_rear_right_speed  <= speed_r[3];
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  // No beat is taken while the sequencer walks the wheels.
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("input taken while busy");

  // A held result stays presented.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r) else $error("result dropped");

  // The divider is only started when it is free.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider restarted while busy");

  // A division finishes only while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_PERW))
    else $error("quotient arrived unexpectedly");
`endif

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the mecanum step-rate drive top level.
`timescale 1ns / 1ps
`default_nettype none
import mecsr_pkg::*;

typedef struct {
  logic [3:0] steps;
  logic [3:0] dirs;
  logic [3:0] motion;
  logic signed [15:0] speed[4];
} drive_result_t;

// Scoreboard: keeps its own copy of the drive state and the expected beats.
class drive_scoreboard;
  int unsigned thr = 35, tfac = 50, top_man = 10, top_auto = 13, ceil_p = 300;
  int speed[4];
  int target[4];
  int unsigned half_per[4];
  int unsigned ticks[4];
  bit level[4];
  drive_result_t pending[$];
  int errors;
  int tbl[15][4] = '{
    '{0, 0, 0, 0}, '{-100, -100, -100, -100}, '{100, 100, 100, 100},
    '{-100, 100, 100, -100}, '{100, -100, -100, 100}, '{-100, 0, 0, -100},
    '{0, -100, -100, 0}, '{0, 100, 100, 0}, '{100, 0, 0, 100},
    '{-100, 100, -100, 100}, '{100, -100, 100, -100}, '{-100, 0, -100, 0},
    '{0, -100, 0, -100}, '{0, 100, 0, 100}, '{100, 0, 100, 0}};

  function void report(string msg);
    errors++;
    $display("MISMATCH: %s", msg);
  endfunction

  function void set_reg(logic [2:0] idx, logic [9:0] v);
    case (idx)
      REG_THRESHOLD: thr = v[6:0];
      REG_TIME_FAC:  tfac = v[7:0];
      REG_TOP_MAN:   top_man = v[7:0];
      REG_TOP_AUTO:  top_auto = v[7:0];
      REG_CEILING:   ceil_p = v;
      default: ;
    endcase
  endfunction

  function int unsigned stick_dist(logic [7:0] b);
    int d;
    d = int'(b) * 200 - 25500;
    return d < 0 ? -d : d;
  endfunction

  // Sort sticks into a motion; a lost link reads as centered sticks.
  function logic [3:0] sort_motion(logic [7:0] tb, logic [7:0] sb, logic [7:0] db,
                                   bit lost);
    int unsigned lim;
    bit t, s, f, tr, sr, fw;
    lim = 255 * thr;
    t = (lost ? 0 : stick_dist(tb)) >= lim;
    s = (lost ? 0 : stick_dist(sb)) >= lim;
    f = (lost ? 0 : stick_dist(db)) >= lim;
    tr = lost || tb >= 128;
    sr = lost || sb >= 128;
    fw = lost || db <= 127;
    if (!t && !s && f) return fw ? MOT_FW : MOT_BW;
    if (!t && s && !f) return sr ? MOT_R : MOT_L;
    if (t && !s && !f) return tr ? MOT_TR : MOT_TL;
    if (s && f) return fw ? (sr ? MOT_FWR : MOT_FWL) : (sr ? MOT_BWR : MOT_BWL);
    if (t && !s && f) return fw ? (tr ? MOT_FWTR : MOT_FWTL) : (tr ? MOT_BWTR : MOT_BWTL);
    return MOT_STOP;
  endfunction

  // Advance the model by one accepted beat and queue the expected result.
  function void note_input(bit tick, logic [7:0] tb, logic [7:0] sb, logic [7:0] db,
                           bit lost, bit auto_m, logic [7:0] host);
    drive_result_t e;
    int unsigned mot, top, a, p;
    bit all_zero;
    longint num, den, n2, d2, r;
    mot = 0;
    if (tick) begin
      for (int i = 0; i < 4; i++) begin
        ticks[i] = (ticks[i] + 1) & 10'h3ff;
        if (half_per[i] != 0 && ticks[i] >= half_per[i]) begin
          level[i] ^= 1'b1;
          ticks[i] = 0;
        end
      end
    end else begin
      mot = auto_m ? host : sort_motion(tb, sb, db, lost);
      if (mot <= 14) begin
        for (int i = 0; i < 4; i++) target[i] = tbl[mot][i];
      end else begin
        mot = 0;
      end
      all_zero = 1;
      for (int i = 0; i < 4; i++) if (target[i] != 0) all_zero = 0;
      top = auto_m ? top_auto : top_man;
      for (int i = 0; i < 4; i++) begin
        if (all_zero) begin
          num = 37 * longint'(speed[i]) + 3 * 256 * target[i];
          den = 40;
        end else begin
          num = 9 * longint'(speed[i]) + 256 * target[i];
          den = 10;
        end
        // Round to nearest, ties toward plus infinity.
        n2 = 2 * num + den;
        d2 = 2 * den;
        r = n2 >= 0 ? n2 / d2 : -((-n2 + d2 - 1) / d2);
        if (r > 25600) r = 25600;
        if (r < -25600) r = -25600;
        speed[i] = int'(r);
        a = r < 0 ? -r : r;
        if (a >= 25600) p = top;
        else if (a > 3328) begin
          p = 25600 * tfac / a - tfac + top;
          if (p > ceil_p) p = ceil_p;
        end else p = 0;
        half_per[i] = p & 10'h3ff;
      end
    end
    for (int i = 0; i < 4; i++) begin
      e.steps[i] = level[i];
      e.speed[i] = speed[i][15:0];
    end
    e.dirs = {speed[3] >= 0, speed[2] < 0, speed[1] >= 0, speed[0] < 0};
    e.motion = mot[3:0];
    pending.push_back(e);
  endfunction

  function void check(drive_result_t got);
    drive_result_t e;
    if (pending.size() == 0) begin
      report("result beat with nothing expected");
      return;
    end
    e = pending.pop_front();
    if (got.steps !== e.steps)
      report($sformatf("step_levels got %h want %h", got.steps, e.steps));
    if (got.dirs !== e.dirs)
      report($sformatf("dir_levels got %h want %h", got.dirs, e.dirs));
    if (got.motion !== e.motion)
      report($sformatf("motion_code got %0d want %0d", got.motion, e.motion));
    for (int i = 0; i < 4; i++)
      if (got.speed[i] !== e.speed[i])
        report($sformatf("wheel %0d speed got %0d want %0d", i, got.speed[i], e.speed[i]));
  endfunction
endclass

module testbench;
  localparam int LIMIT = 2000000;
  // An index that names no register.
  localparam logic [2:0] REG_NONE = 3'd7;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [9:0] cfg_wdata = '0;
  logic in_valid = 0, in_action = 0, in_link_lost = 0, in_auto_mode = 0;
  logic [7:0] in_turn_stick = 0, in_side_stick = 0, in_drive_stick = 0;
  logic [7:0] in_host_direction = 0;
  logic in_stall, out_valid, out_stall = 0;
  logic [3:0] out_step_levels, out_dir_levels, out_motion_code;
  logic signed [15:0] out_front_left_speed, out_front_right_speed;
  logic signed [15:0] out_rear_left_speed, out_rear_right_speed;

  int send_idle_pct = 0, recv_idle_pct = 0;
  int cycles = 0;
  drive_scoreboard sb = new();

  mecanum_step_rate_drive_top dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver stalls at random, decided at the falling edge.
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // Check every result beat taken at the rising edge.
  always @(posedge clk) begin
    drive_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.steps = out_step_levels;
      got.dirs = out_dir_levels;
      got.motion = out_motion_code;
      got.speed[0] = out_front_left_speed;
      got.speed[1] = out_front_right_speed;
      got.speed[2] = out_rear_left_speed;
      got.speed[3] = out_rear_right_speed;
      sb.check(got);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_beat(bit tick, logic [7:0] tb, logic [7:0] sbk, logic [7:0] db,
                           bit lost, bit auto_m, logic [7:0] host);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_action = tick;
    in_turn_stick = tb;
    in_side_stick = sbk;
    in_drive_stick = db;
    in_link_lost = lost;
    in_auto_mode = auto_m;
    in_host_direction = host;
    do @(posedge clk); while (in_stall);
    sb.note_input(tick, tb, sbk, db, lost, auto_m, host);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic send_update(logic [7:0] tb, logic [7:0] sbk, logic [7:0] db,
                             bit lost, bit auto_m, logic [7:0] host);
    send_beat(0, tb, sbk, db, lost, auto_m, host);
  endtask

  task automatic send_tick();
    send_beat(1, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
              8'($urandom));
  endtask

  // Registers change only with the block drained and settled.
  task automatic write_reg(logic [2:0] idx, logic [9:0] v);
    wait (sb.pending.size() == 0);
    repeat (4) @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic logic [7:0] stick_byte();
    case ($urandom_range(4))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'(127 + $urandom_range(1));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_beats(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 60) send_tick();
      else send_update(stick_byte(), stick_byte(), stick_byte(),
                       $urandom_range(9) == 0, $urandom_range(2) == 0,
                       $urandom_range(9) == 0 ? 8'($urandom) : 8'($urandom_range(14)));
    end
  endtask

  initial begin
    static logic [3:0] mots[15] = '{MOT_STOP, MOT_FW, MOT_BW, MOT_L, MOT_R, MOT_FWL,
                                    MOT_FWR, MOT_BWL, MOT_BWR, MOT_TL, MOT_TR, MOT_FWTL,
                                    MOT_FWTR, MOT_BWTL, MOT_BWTR};
    repeat (11) @(negedge clk);
    rst_n = 1;
    send_idle_pct = 26;
    recv_idle_pct = 62;

    // Directed: stick extremes, every host motion, host codes out of range.
    send_update(8'd0, 8'd128, 8'd127, 0, 0, 8'd0);
    send_update(8'd255, 8'd0, 8'd255, 0, 0, 8'd0);
    send_update(8'd128, 8'd255, 8'd0, 0, 0, 8'd0);
    for (int m = 0; m < 15; m++) begin
      send_update(8'd0, 8'd0, 8'd0, 0, 1, 8'(mots[m]));
      send_tick();
    end
    send_update(8'd0, 8'd0, 8'd0, 0, 1, 8'd15);
    send_update(8'd255, 8'd255, 8'd255, 1, 1, 8'd255);

    // Centered sticks count as movement with a zero threshold.
    write_reg(REG_THRESHOLD, 10'd0);
    send_update(8'd127, 8'd128, 8'd127, 1, 0, 8'd0);
    send_update(8'd127, 8'd127, 8'd127, 0, 0, 8'd0);
    write_reg(REG_NONE, 10'h3ff);
    random_beats(150);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_THRESHOLD, 10'd100); write_reg(REG_TIME_FAC, 10'd0);
          write_reg(REG_TOP_MAN, 10'd0); write_reg(REG_TOP_AUTO, 10'd0);
          write_reg(REG_CEILING, 10'd0);
        end
        1: begin
          write_reg(REG_THRESHOLD, 10'h3ff); write_reg(REG_TIME_FAC, 10'd255);
          write_reg(REG_TOP_MAN, 10'd255); write_reg(REG_TOP_AUTO, 10'd255);
          write_reg(REG_CEILING, 10'd1023);
          send_idle_pct = 62;
          recv_idle_pct = 26;
        end
        2: begin
          write_reg(REG_THRESHOLD, 10'd35); write_reg(REG_TIME_FAC, 10'd50);
          write_reg(REG_TOP_MAN, 10'd3); write_reg(REG_TOP_AUTO, 10'd13);
          write_reg(REG_CEILING, 10'd40);
        end
        default: begin
          write_reg(REG_THRESHOLD, 10'($urandom_range(100)));
          write_reg(REG_TIME_FAC, 10'($urandom));
          write_reg(REG_TOP_MAN, 10'($urandom_range(20)));
          write_reg(REG_TOP_AUTO, 10'($urandom));
          write_reg(REG_CEILING, 10'($urandom));
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      random_beats(170);
    end

    wait (sb.pending.size() == 0);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
